// File: hw/rtl/cia_pkg.sv
package cia_pkg;

	// command codes carried by the cmd field
	localparam logic CMD_ALLOC  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// status codes of a result
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MISS = 2'd2;

endpackage

// File: hw/rtl/cyclic_id_allocator_with_lookup.sv
// Identifier allocator with lookup. Identifiers in use sit in a single-port-write,
// registered-read table memory; slots fill from 0 upward and are never freed, so the
// entry count alone marks which slots hold data and no clearing pass follows reset.
// An allocate goes straight from acceptance to its result when the next identifier
// lies below the safe bound (or the table is full); otherwise a rescan walks the
// table memory from the newest slot down, one entry a cycle, and a pass restarts
// from the newest slot whenever the candidate collides at the bound. A lookup walks
// the table from slot 0 upward through the memory read port until a hit or the last
// entry; an identifier out of range or an empty table gives a miss without a walk.
// One item is worked on at a time; a finished result sits in an output register
// so a new transaction is taken while it waits.
module cyclic_id_allocator_with_lookup #(
	parameter int TABLE_DEPTH = 64,
	parameter int ID_LIMIT = 128,
	localparam int ID_W = $clog2(ID_LIMIT),
	localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [ID_W-1:0]   query_id,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic [ID_W-1:0]   result_id,
	output logic [SLOT_W-1:0] slot
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LG_W = $clog2(ID_LIMIT + 2);
	localparam int RST_W = $clog2(ID_LIMIT + 4);

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOK,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LG_W-1:0]   lg_q;
	logic [LG_W-1:0]   sb_q;
	logic [RST_W-1:0]  rst_q;
	logic [SLOT_W-1:0] ptr_q;
	logic              iss_q;
	logic              vld_s1;
	logic [SLOT_W-1:0] idx_s1;
	logic [ID_W-1:0]   qid_q;
	logic [1:0]        res_st_q;
	logic [ID_W-1:0]   res_id_q;
	logic [SLOT_W-1:0] res_sl_q;
	logic              out_vld_q;
	logic [1:0]        out_st_q;
	logic [ID_W-1:0]   out_id_q;
	logic [SLOT_W-1:0] out_sl_q;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [ID_W-1:0]   mem_wdata;
	logic              mem_re;
	logic [ID_W-1:0]   mem_rdata;

	logic [LG_W-1:0]   lg_inc;
	logic [LG_W-1:0]   ent;
	logic [SLOT_W-1:0] last_slot;
	logic              alloc_full;
	logic              q_oor;
	logic              accept;
	logic [LG_W-1:0]   lg_n;
	logic [LG_W-1:0]   sb_n;
	logic              restart;
	logic              abort;
	logic              scan_end;
	logic              lk_hit;
	logic              lk_end;
	logic              out_load;

	cia_mem #(
		.DEPTH(TABLE_DEPTH),
		.DATA_W(ID_W)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(ptr_q),
		.rdata(mem_rdata)
	);

	// common terms
	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign lg_inc = lg_q + LG_W'(1);
	assign ent = LG_W'(mem_rdata);
	assign last_slot = SLOT_W'(cnt_q - CNT_W'(1));
	assign alloc_full = (32'(cnt_q) >= TABLE_DEPTH) || (32'(cnt_q) + 32'd1 >= ID_LIMIT);
	assign q_oor = (query_id == '0) || (32'(query_id) >= ID_LIMIT);
	assign out_load = (state_q == S_DONE) && (!out_vld_q || out_ready);

	// rescan compare on the entry returned by the memory
	always_comb begin
		lg_n = lg_q;
		sb_n = sb_q;
		restart = 1'b0;
		abort = 1'b0;
		if (vld_s1) begin
			if (ent == lg_q) begin
				lg_n = lg_inc;
				if (lg_inc >= sb_q) begin
					if (lg_inc >= LG_W'(ID_LIMIT)) begin
						lg_n = LG_W'(1);
					end
					sb_n = LG_W'(ID_LIMIT);
					restart = 1'b1;
					abort = (rst_q >= RST_W'(ID_LIMIT + 2));
				end
			end else if (ent > lg_q && sb_q > ent) begin
				sb_n = ent;
			end
		end
	end
	assign scan_end = abort || (!restart && !iss_q);

	// lookup compare
	assign lk_hit = vld_s1 && (mem_rdata == qid_q);
	assign lk_end = lk_hit || (vld_s1 && !iss_q);

	// memory access
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = SLOT_W'(cnt_q);
		mem_wdata = ID_W'(lg_n);
		mem_re = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd == cia_pkg::CMD_ALLOC && !alloc_full
						&& lg_inc < LG_W'(ID_LIMIT) && lg_inc < sb_q) begin
					mem_we = 1'b1;
					mem_wdata = ID_W'(lg_inc);
				end
			end
			S_SCAN: begin
				mem_re = iss_q;
				mem_we = scan_end;
			end
			S_LOOK: begin
				mem_re = iss_q;
			end
			S_DONE: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	// sequencer, table state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			lg_q <= LG_W'(ID_LIMIT);
			sb_q <= LG_W'(ID_LIMIT);
			rst_q <= '0;
			ptr_q <= '0;
			iss_q <= 1'b0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
			qid_q <= '0;
			res_st_q <= cia_pkg::ST_OK;
			res_id_q <= '0;
			res_sl_q <= '0;
			out_vld_q <= 1'b0;
			out_st_q <= cia_pkg::ST_OK;
			out_id_q <= '0;
			out_sl_q <= '0;
		end else begin
			// output register
			if (out_load) begin
				out_vld_q <= 1'b1;
				out_st_q <= res_st_q;
				out_id_q <= res_id_q;
				out_sl_q <= res_sl_q;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						qid_q <= query_id;
						if (cmd == cia_pkg::CMD_ALLOC) begin
							if (alloc_full) begin
								res_st_q <= cia_pkg::ST_FULL;
								res_id_q <= '0;
								res_sl_q <= '0;
								state_q <= S_DONE;
							end else if (lg_inc >= LG_W'(ID_LIMIT) || lg_inc >= sb_q) begin
								// candidate wrapped or reached the safe bound: rescan
								lg_q <= (lg_inc >= LG_W'(ID_LIMIT)) ? LG_W'(1) : lg_inc;
								sb_q <= LG_W'(ID_LIMIT);
								rst_q <= '0;
								ptr_q <= last_slot;
								iss_q <= (cnt_q != '0);
								state_q <= S_SCAN;
							end else begin
								lg_q <= lg_inc;
								cnt_q <= cnt_q + CNT_W'(1);
								res_st_q <= cia_pkg::ST_OK;
								res_id_q <= ID_W'(lg_inc);
								res_sl_q <= SLOT_W'(cnt_q);
								state_q <= S_DONE;
							end
						end else begin
							if (q_oor || cnt_q == '0) begin
								res_st_q <= cia_pkg::ST_MISS;
								res_id_q <= '0;
								res_sl_q <= '0;
								state_q <= S_DONE;
							end else begin
								ptr_q <= '0;
								iss_q <= 1'b1;
								state_q <= S_LOOK;
							end
						end
					end
				end

				S_SCAN: begin
					lg_q <= lg_n;
					sb_q <= sb_n;
					if (scan_end) begin
						cnt_q <= cnt_q + CNT_W'(1);
						res_st_q <= cia_pkg::ST_OK;
						res_id_q <= ID_W'(lg_n);
						res_sl_q <= SLOT_W'(cnt_q);
						iss_q <= 1'b0;
						vld_s1 <= 1'b0;
						state_q <= S_DONE;
					end else if (restart) begin
						// collision at the bound: start a new pass from the newest slot
						rst_q <= rst_q + RST_W'(1);
						ptr_q <= last_slot;
						iss_q <= 1'b1;
						vld_s1 <= 1'b0;
					end else begin
						vld_s1 <= iss_q;
						idx_s1 <= ptr_q;
						if (iss_q) begin
							if (ptr_q == '0) begin
								iss_q <= 1'b0;
							end else begin
								ptr_q <= ptr_q - SLOT_W'(1);
							end
						end
					end
				end

				S_LOOK: begin
					if (lk_end) begin
						iss_q <= 1'b0;
						vld_s1 <= 1'b0;
						res_st_q <= lk_hit ? cia_pkg::ST_OK : cia_pkg::ST_MISS;
						res_id_q <= lk_hit ? qid_q : '0;
						res_sl_q <= lk_hit ? idx_s1 : '0;
						state_q <= S_DONE;
					end else begin
						vld_s1 <= iss_q;
						idx_s1 <= ptr_q;
						if (iss_q) begin
							if (ptr_q == last_slot) begin
								iss_q <= 1'b0;
							end else begin
								ptr_q <= ptr_q + SLOT_W'(1);
							end
						end
					end
				end

				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;
	assign status = out_st_q;
	assign result_id = out_id_q;
	assign slot = out_sl_q;

endmodule

// File: hw/rtl/cia_mem.sv
module cia_mem #(
	parameter int DEPTH = 64,
	parameter int DATA_W = 7,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/cia_chk.sv
module cia_chk #(
	parameter int ID_W = 7,
	parameter int SLOT_W = 6
) (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [ID_W-1:0]   result_id,
	input logic [SLOT_W-1:0] slot
);

	// a stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status)
			&& $stable(result_id) && $stable(slot))
		else $error("result changed while stalled");

	// failed requests carry zero identifier and slot
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != cia_pkg::ST_OK |-> result_id == '0 && slot == '0)
		else $error("nonzero payload on failed result");

	// a successful result never names identifier zero
	a_ok_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == cia_pkg::ST_OK |-> result_id != '0)
		else $error("identifier zero reported as valid");

endmodule

bind cyclic_id_allocator_with_lookup cia_chk #(
	.ID_W(ID_W),
	.SLOT_W(SLOT_W)
) u_cia_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.status(status),
	.result_id(result_id),
	.slot(slot)
);
